### sv/mabl_pkg.sv
// Shared types and constants for the masked AND set-bit lister.
package mabl_pkg;

  localparam int WORD_BITS = 64;
  localparam int WORD_LOG2 = 6;
  localparam int LIMIT_W = 11;
  localparam int POS_W = 5;
  localparam int COUNT_W = 11;
  localparam int OUT_W = 10;

  localparam logic [LIMIT_W-1:0] MAX_VERTICES = 11'd1024;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic word_nz;
    logic last_bit;
    logic out_free;
  } sts_t;

endpackage

### sv/mabl_ctrl.sv
// Controller state machine for the masked AND set-bit lister.
module mabl_ctrl
  import mabl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.word_nz) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free && sts.last_bit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/mabl_dp.sv
// Datapath: limit register, word masking, lowest-bit extraction and result register.
module mabl_dp
  import mabl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  input  logic                 in_first_word,
  input  logic [WORD_BITS-1:0] in_word_a,
  input  logic [WORD_BITS-1:0] in_word_b,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_vertex,
  output logic [OUT_W-1:0]     out_slot,
  output logic                 out_last_of_word
);

  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     cur_pos_r, cur_pos_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_vertex_r, out_vertex_nxt;
  logic [OUT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [LIMIT_W-1:0]   lim;
  logic [POS_W-1:0]     limit_word;
  logic [WORD_LOG2-1:0] limit_bit;
  logic [POS_W-1:0]     pos_eff;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] iso;
  logic [WORD_BITS-1:0] rem_clr;
  logic [WORD_LOG2-1:0] bit_idx;

  // Limits above the vertex range act as the range itself.
  always_comb begin
    lim = (limit_r > MAX_VERTICES) ? MAX_VERTICES : limit_r;
    limit_word = lim[LIMIT_W-1:WORD_LOG2];
    limit_bit = lim[WORD_LOG2-1:0];
    pos_eff = in_first_word ? '0 : pos_r;
  end

  // The word holding the limit keeps only the bits below it; later words give nothing.
  always_comb begin
    if (pos_eff < limit_word) begin
      masked = in_word_a & in_word_b;
    end else if (pos_eff == limit_word) begin
      masked = in_word_a & in_word_b & ~({WORD_BITS{1'b1}} << limit_bit);
    end else begin
      masked = '0;
    end
  end

  // Isolate the lowest set bit with a two's complement and encode its position.
  always_comb begin
    iso = rem_r & (~rem_r + {{(WORD_BITS-1){1'b0}}, 1'b1});
    rem_clr = rem_r & ~iso;
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        bit_idx = bit_idx | WORD_LOG2'(i);
      end
    end
  end

  assign sts.word_nz = (masked != '0);
  assign sts.last_bit = (rem_clr == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;
    pos_nxt = pos_r;
    cur_pos_nxt = cur_pos_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_vertex_nxt = out_vertex_r;
    out_slot_nxt = out_slot_r;
    out_last_nxt = out_last_r;
    if (cmd.load) begin
      rem_nxt = masked;
      cur_pos_nxt = pos_eff;
      pos_nxt = (pos_eff == POS_MAX) ? pos_eff : pos_eff + 1'b1;
      if (in_first_word) begin
        cnt_nxt = '0;
      end
    end
    if (cmd.emit) begin
      rem_nxt = rem_clr;
      out_valid_nxt = 1'b1;
      out_vertex_nxt = {cur_pos_r[OUT_W-WORD_LOG2-1:0], bit_idx};
      out_slot_nxt = cnt_r[OUT_W-1:0];
      out_last_nxt = (rem_clr == '0);
      cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      pos_r <= '0;
      cnt_r <= '0;
      rem_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r <= limit_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_pos_r <= cur_pos_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_slot = out_slot_r;
  assign out_last_of_word = out_last_r;

`ifndef SYNTHESIS
  a_emit_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> rem_r != '0)
    else $error("emit with no bits left in the word");

  a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> rem_r == '0)
    else $error("new word loaded before the previous one drained");

  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && (rem_clr == '0) |=> out_last_r && out_valid_r && (rem_r == '0))
    else $error("final bit of a word not marked as last");
`endif

endmodule

### sv/masked_and_set_bit_lister.sv
// Top level of the masked AND set-bit lister.
//
//   channel | direction | ports                                        | handshake
//   --------+-----------+----------------------------------------------+-------------------
//   in      | in        | in_first_word, in_word_a, in_word_b          | in_valid/in_stall
//   out     | out       | out_vertex, out_slot, out_last_of_word       | out_valid/out_stall
//   cfg     | in        | cfg_wr_data (vertex limit)                   | cfg_wr_en
//
// A word pair is accepted first; then each set bit that survives the mask is emitted by
// the single lowest-bit extractor, one index per cycle while the output is not stalled.
// A word with no surviving bits is done in its accept cycle.
// Reset is synchronous and active low; it clears the limit, word position and count.
// A stall on the output holds the result register and pauses extraction; the next
// word is accepted while the last beat of the previous one still waits.
module masked_and_set_bit_lister
  import mabl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_first_word,
  input  logic [WORD_BITS-1:0] in_word_a,
  input  logic [WORD_BITS-1:0] in_word_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_vertex,
  output logic [OUT_W-1:0]     out_slot,
  output logic                 out_last_of_word
);

  cmd_t cmd;
  sts_t sts;

  mabl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  mabl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_first_word    (in_first_word),
    .in_word_a        (in_word_a),
    .in_word_b        (in_word_b),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_vertex       (out_vertex),
    .out_slot         (out_slot),
    .out_last_of_word (out_last_of_word)
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the masked AND set-bit lister.
`timescale 1ns / 1ps

module tb_top
  import mabl_pkg::*;
();

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT = 23;
  localparam logic [WORD_BITS-1:0] ONES = '1;
  localparam logic [WORD_BITS-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [OUT_W-1:0] vertex;
    logic [OUT_W-1:0] slot;
    logic             last;
  } hit_t;

  // Hand-written expectation for a directed word: hit count and first hit.
  typedef struct packed {
    bit               typed;
    logic [6:0]       n_hits;
    logic [OUT_W-1:0] v0;
    logic [OUT_W-1:0] s0;
  } word_note_t;

  typedef struct packed {
    bit                   wr;
    logic [LIMIT_W-1:0]   lim;
    logic                 first;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    word_note_t           note;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_first_word = 1'b0;
  logic [WORD_BITS-1:0] in_word_a = '0;
  logic [WORD_BITS-1:0] in_word_b = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_vertex;
  logic [OUT_W-1:0]     out_slot;
  logic                 out_last_of_word;

  // Predictor state.
  logic [LIMIT_W-1:0] limit_reg;
  logic [POS_W-1:0]   word_pos;
  logic [COUNT_W-1:0] found_cnt;

  hit_t       pending_hits[$];
  word_note_t word_notes[$];
  int         err_count = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  dir_row_t dir_rows [20] = '{
    '{1'b0, 11'd0,    1'b1, ONES, ONES, '{1'b1, 7'd0,  10'd0,   10'd0}},
    '{1'b1, 11'd1024, 1'b1, ONES, ONES, '{1'b1, 7'd64, 10'd0,   10'd0}},
    '{1'b0, 11'd0,    1'b0, ONES, '0,   '{1'b1, 7'd0,  10'd0,   10'd0}},
    '{1'b0, 11'd0,    1'b0, '0,   ONES, '{1'b1, 7'd0,  10'd0,   10'd0}},
    '{1'b0, 11'd0,    1'b0, TOP_BIT, ONES, '{1'b1, 7'd1, 10'd255, 10'd64}},
    '{1'b0, 11'd0,    1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      '{1'b1, 7'd0, 10'd0, 10'd0}},
    '{1'b0, 11'd0,    1'b0, 64'h8000_0000_0000_0001, 64'hC000_0000_0000_0003,
      '{1'b0, 7'd0, 10'd0, 10'd0}},
    '{1'b1, 11'd2047, 1'b1, ONES, ONES, '{1'b1, 7'd64, 10'd0,   10'd0}},
    '{1'b1, 11'd64,   1'b1, ONES, ONES, '{1'b1, 7'd64, 10'd0,   10'd0}},
    '{1'b0, 11'd0,    1'b0, ONES, ONES, '{1'b1, 7'd0,  10'd0,   10'd0}},
    '{1'b0, 11'd0,    1'b0, ONES, ONES, '{1'b1, 7'd0,  10'd0,   10'd0}},
    '{1'b1, 11'd100,  1'b1, ONES, ONES, '{1'b1, 7'd64, 10'd0,   10'd0}},
    '{1'b0, 11'd0,    1'b0, ONES, ONES, '{1'b1, 7'd36, 10'd64,  10'd64}},
    '{1'b1, 11'd1,    1'b1, ONES, ONES, '{1'b1, 7'd1,  10'd0,   10'd0}},
    '{1'b1, 11'd1023, 1'b1, ONES, TOP_BIT, '{1'b1, 7'd1, 10'd63, 10'd0}},
    '{1'b0, 11'd0,    1'b0, 64'h0F0F_1234_8765_F0F0, 64'h3C3C_FFFF_0000_C3C3,
      '{1'b0, 7'd0, 10'd0, 10'd0}},
    '{1'b1, 11'd0,    1'b1, ONES, ONES, '{1'b1, 7'd0,  10'd0,   10'd0}},
    '{1'b1, 11'd1000, 1'b1, 64'hDEAD_BEEF_0123_4567, 64'hFFFF_0000_FFFF_0000,
      '{1'b0, 7'd0, 10'd0, 10'd0}},
    '{1'b0, 11'd0,    1'b0, ONES, 64'h8000_0000_0000_0001, '{1'b0, 7'd0, 10'd0, 10'd0}},
    '{1'b0, 11'd0,    1'b1, '0,   '0,   '{1'b1, 7'd0,  10'd0,   10'd0}}
  };

  masked_and_set_bit_lister u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_word    (in_first_word),
    .in_word_a        (in_word_a),
    .in_word_b        (in_word_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex       (out_vertex),
    .out_slot         (out_slot),
    .out_last_of_word (out_last_of_word)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Queue the index list that one accepted word pair should produce.
  function automatic void predict_hits(logic first, logic [WORD_BITS-1:0] a,
                                       logic [WORD_BITS-1:0] b);
    logic [LIMIT_W-1:0]   lim;
    logic [WORD_BITS-1:0] w;
    int                   lim_word;
    int                   pos;
    int                   v;
    hit_t                 h;
    if (first) begin
      word_pos = '0;
      found_cnt = '0;
    end
    pos = word_pos;
    lim = (limit_reg > MAX_VERTICES) ? MAX_VERTICES : limit_reg;
    lim_word = lim >> WORD_LOG2;
    w = a & b;
    if (pos > lim_word) begin
      w = '0;
    end else if (pos == lim_word) begin
      // A zero bit offset leaves an empty mask, so the limit word gives nothing.
      w &= (64'd1 << lim[WORD_LOG2-1:0]) - 64'd1;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        v = pos * WORD_BITS + i;
        h.vertex = OUT_W'(v);
        h.slot = found_cnt[OUT_W-1:0];
        h.last = ((w >> (i + 1)) == '0);
        pending_hits.push_back(h);
        if (found_cnt < COUNT_MAX) found_cnt++;
      end
    end
    if (word_pos < POS_MAX) word_pos++;
  endfunction

  always @(posedge clk) begin
    hit_t       want;
    word_note_t nt;
    int         base;
    if (!rst_n) begin
      limit_reg = '0;
      word_pos = '0;
      found_cnt = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected beat: vertex %0d slot %0d", out_vertex, out_slot);
          err_count++;
        end else begin
          want = pending_hits.pop_front();
          if (out_vertex !== want.vertex) begin
            $error("vertex: expected %0d, got %0d", want.vertex, out_vertex);
            err_count++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_slot);
            err_count++;
          end
          if (out_last_of_word !== want.last) begin
            $error("last_of_word: expected %0d, got %0d", want.last, out_last_of_word);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        nt = word_notes.pop_front();
        base = pending_hits.size();
        predict_hits(in_first_word, in_word_a, in_word_b);
        if (nt.typed) begin
          if (pending_hits.size() - base != nt.n_hits) begin
            $error("n_hits: expected %0d, got %0d", nt.n_hits, pending_hits.size() - base);
            err_count++;
          end else if (nt.n_hits != 0 && (pending_hits[base].vertex != nt.v0 ||
                                          pending_hits[base].slot != nt.s0)) begin
            $error("first hit: expected %0d/%0d, got %0d/%0d", nt.v0, nt.s0,
                   pending_hits[base].vertex, pending_hits[base].slot);
            err_count++;
          end
        end
      end
      // A limit written at this edge only affects words accepted later.
      if (cfg_wr_en) limit_reg = cfg_wr_data;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_word(logic first, logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b,
                           word_note_t nt);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    word_notes.push_back(nt);
    in_valid <= 1'b1;
    in_first_word <= first;
    in_word_a <= a;
    in_word_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hits.size() != 0);
    // A word with no surviving bits leaves nothing queued to wait on.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic pick_pair(output logic [WORD_BITS-1:0] a, output logic [WORD_BITS-1:0] b);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end
      5: begin
        a = ONES;
        b = {$urandom, $urandom};
      end
      6: begin
        a = {$urandom, $urandom} & {$urandom, $urandom};
        b = {$urandom, $urandom};
      end
      7: begin
        a = {$urandom, $urandom};
        b = '0;
      end
      8: begin
        a = ONES;
        b = ONES;
      end
      default: begin
        a = 64'd1 << $urandom_range(WORD_BITS - 1);
        b = ONES;
      end
    endcase
  endtask

  // Runs of words that open with a restart; now and then the restart is
  // missing or a stray one lands mid-run.
  task automatic random_phase(int n_words);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic                 first;
    int                   run_len;
    int                   sent;
    sent = 0;
    while (sent < n_words) begin
      run_len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      for (int j = 0; j < run_len && sent < n_words; j++) begin
        first = (j == 0) ? ($urandom_range(99) < 93) : ($urandom_range(99) < 3);
        pick_pair(a, b);
        send_word(first, a, b, '0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        wait_idle();
        write_limit(dir_rows[i].lim);
      end
      send_word(dir_rows[i].first, dir_rows[i].a, dir_rows[i].b, dir_rows[i].note);
    end

    // No idling on either side for this stretch.
    wait_idle();
    calm = 1'b1;
    write_limit(11'd1024);
    random_phase(20);

    wait_idle();
    calm = 1'b0;
    write_limit(11'd700);
    hold_req = 1'b1;
    random_phase(20);

    // Walk the word position past the end so it saturates.
    wait_idle();
    write_limit(11'd2047);
    for (int j = 0; j < 36; j++) begin
      pick_pair(a, b);
      send_word(j == 0, a, b, '0);
    end
    random_phase(15);

    wait_idle();
    write_limit(11'($urandom_range(1, 1023)));
    random_phase(20);

    wait_idle();
    write_limit(11'($urandom_range(0, 2047)));
    random_phase(20);

    wait_idle();
    if (err_count == 0 && pending_hits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
